>>> sv/qrs_pkg.sv
// Shared widths, types, codes and arithmetic helpers for the quadratic root solver.
// No dependencies; every other file refers to this package by scoped names.
package qrs_pkg;

    // Number format
    localparam int FRAC_BITS  = 16;
    localparam int COEF_WIDTH = 32;
    localparam int TOL_WIDTH  = 16;

    // Derived widths
    localparam int DISC_W = 2 * COEF_WIDTH + 2;      // exact b^2 - 4ac magnitude, even
    localparam int SQRT_W = DISC_W / 2;              // one root bit per sqrt cell
    localparam int SREM_W = SQRT_W + 3;              // sqrt partial remainder
    localparam int NUM_W  = COEF_WIDTH + 2;          // |b| + sqrt
    localparam int DEN_W  = COEF_WIDTH + 1;          // 2|a|
    localparam int NSH_W  = NUM_W + FRAC_BITS;       // numerator scaled by 2^FRAC_BITS
    localparam int CMP_W  = (NSH_W > DEN_W + COEF_WIDTH) ? NSH_W : DEN_W + COEF_WIDTH;
    localparam int DCMP_W = DISC_W + TOL_WIDTH + FRAC_BITS;

    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic [COEF_WIDTH-1:0]        t_mag;
    typedef logic [2*COEF_WIDTH-1:0]      t_prod;
    typedef logic [DISC_W-1:0]            t_disc;
    typedef logic [SQRT_W-1:0]            t_sqrt;
    typedef logic [SREM_W-1:0]            t_srem;
    typedef logic [NUM_W-1:0]             t_num;
    typedef logic [DEN_W-1:0]             t_den;
    typedef logic [CMP_W-1:0]             t_cmp;
    typedef logic [DCMP_W-1:0]            t_dcmp;
    typedef logic [TOL_WIDTH-1:0]         t_tol;
    typedef logic [1:0]                   t_cnt;
    typedef logic [1:0]                   t_case;

    // Root count codes
    localparam t_cnt CNT_NONE = 2'd0;
    localparam t_cnt CNT_ONE  = 2'd1;
    localparam t_cnt CNT_TWO  = 2'd2;
    localparam t_cnt CNT_INF  = 2'd3;

    // Coefficient case codes
    localparam t_case CS_INF  = 2'd0;
    localparam t_case CS_NONE = 2'd1;
    localparam t_case CS_LIN  = 2'd2;
    localparam t_case CS_QUAD = 2'd3;

    localparam t_mag POS_LIM = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam t_mag NEG_LIM = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    // Data handed from one sqrt cell to the next
    typedef struct packed {
        t_disc rad;
        t_srem rem;
        t_sqrt root;
    } t_sq_cell;

    // Data handed from one divider cell to the next
    typedef struct packed {
        t_den rem;
        t_den den;
        t_mag nbits;
        t_mag quo;
    } t_dv_cell;

    // Sign-magnitude value
    typedef struct packed {
        logic neg;
        t_num mag;
    } t_sm;

    // Per-divider flags that travel beside the divider cells
    typedef struct packed {
        logic sn;
        logic neg;
        logic nz;
        logic dz;
        logic ovf;
    } t_dv_flags;

    typedef struct packed {
        t_dv_flags f;
        t_dv_cell  c;
    } t_dv_pre;

    typedef struct packed {
        t_mag val;
        logic sat;
    } t_root;

    // Sign-magnitude add; a zero result is positive
    function automatic t_sm sm_add(input logic neg_a, input t_num mag_a,
                                   input logic neg_b, input t_num mag_b);
        t_sm r;
        if (neg_a == neg_b) begin
            r.neg = neg_a;
            r.mag = mag_a + mag_b;
        end else if (mag_a >= mag_b) begin
            r.neg = neg_a;
            r.mag = mag_a - mag_b;
        end else begin
            r.neg = neg_b;
            r.mag = mag_b - mag_a;
        end
        if (r.mag == '0) begin
            r.neg = 1'b0;
        end
        return r;
    endfunction

    // Divider setup: overflow pre-check and the first partial remainder
    function automatic t_dv_pre dv_pre(input t_sm num, input logic den_neg, input t_den den);
        t_cmp    nsh;
        t_cmp    dsh;
        t_dv_pre r;
        nsh = t_cmp'(num.mag) << FRAC_BITS;
        dsh = t_cmp'(den) << COEF_WIDTH;
        r.f.sn    = num.neg;
        r.f.neg   = num.neg ^ den_neg;
        r.f.nz    = (num.mag == '0);
        r.f.dz    = (den == '0);
        r.f.ovf   = (nsh >= dsh);
        r.c.rem   = t_den'(nsh >> COEF_WIDTH);
        r.c.den   = den;
        r.c.nbits = nsh[COEF_WIDTH-1:0];
        r.c.quo   = '0;
        return r;
    endfunction

    // Sign, clamp and zero-divisor handling of a finished quotient
    function automatic t_root root_out(input t_dv_flags f, input t_mag quo);
        t_mag  lim;
        t_mag  q;
        t_root r;
        r.val = '0;
        r.sat = 1'b0;
        lim   = f.neg ? NEG_LIM : POS_LIM;
        q     = quo;
        if (f.nz) begin
            r.val = '0;
        end else if (f.dz) begin
            r.sat = 1'b1;
            r.val = f.sn ? NEG_LIM : POS_LIM;
        end else begin
            if (f.ovf || (quo > lim)) begin
                q     = lim;
                r.sat = 1'b1;
            end
            r.val = f.neg ? (~q + t_mag'(1)) : q;
        end
        return r;
    endfunction

endpackage

>>> sv/qrs_in_if.sv
// Coefficient channel: valid/ready handshake carrying one equation per item.
// Depends on qrs_pkg for the coefficient type.
interface qrs_in_if;
    logic           valid;
    logic           ready;
    qrs_pkg::t_coef coef_a;
    qrs_pkg::t_coef coef_b;
    qrs_pkg::t_coef coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

>>> sv/qrs_out_if.sv
// Result channel: valid/ready handshake carrying the root count and roots.
// Depends on qrs_pkg for the root and count types.
interface qrs_out_if;
    logic          valid;
    logic          ready;
    qrs_pkg::t_cnt root_count;
    qrs_pkg::t_mag root_minus;
    qrs_pkg::t_mag root_plus;
    logic          saturated;

    modport source (output valid, output root_count, output root_minus, output root_plus,
                    output saturated, input ready);
    modport sink   (input valid, input root_count, input root_minus, input root_plus,
                    input saturated, output ready);
endinterface

>>> sv/qrs_sqrt_cell.sv
// One cell of the square-root chain: resolves one root bit per cell.
// Depends on qrs_pkg for the cell data type.
module qrs_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_en,
    input  qrs_pkg::t_sq_cell i_d,
    output qrs_pkg::t_sq_cell o_q
);
    qrs_pkg::t_srem    w_t;
    qrs_pkg::t_srem    w_trial;
    qrs_pkg::t_sq_cell n_q;
    qrs_pkg::t_sq_cell r_q;

    // Bring down two radicand bits and try root*4+1
    always_comb begin
        w_t     = {i_d.rem[qrs_pkg::SREM_W-3:0], i_d.rad[qrs_pkg::DISC_W-1 -: 2]};
        w_trial = qrs_pkg::t_srem'({i_d.root, 2'b01});
        n_q.rad = i_d.rad << 2;
        if (w_t >= w_trial) begin
            n_q.rem  = w_t - w_trial;
            n_q.root = {i_d.root[qrs_pkg::SQRT_W-2:0], 1'b1};
        end else begin
            n_q.rem  = w_t;
            n_q.root = {i_d.root[qrs_pkg::SQRT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

>>> sv/qrs_div_cell.sv
// One cell of a restoring divider chain: resolves one quotient bit per cell.
// Depends on qrs_pkg for the cell data type.
module qrs_div_cell (
    input  logic              i_clk,
    input  logic              i_en,
    input  qrs_pkg::t_dv_cell i_d,
    output qrs_pkg::t_dv_cell o_q
);
    logic [qrs_pkg::DEN_W:0] w_t;
    logic [qrs_pkg::DEN_W:0] w_d;
    qrs_pkg::t_dv_cell       n_q;
    qrs_pkg::t_dv_cell       r_q;

    // Shift in the next numerator bit, subtract the divisor when it fits
    always_comb begin
        w_t       = {i_d.rem, i_d.nbits[qrs_pkg::COEF_WIDTH-1]};
        w_d       = {1'b0, i_d.den};
        n_q.den   = i_d.den;
        n_q.nbits = i_d.nbits << 1;
        if (w_t >= w_d) begin
            n_q.rem = qrs_pkg::t_den'(w_t - w_d);
            n_q.quo = {i_d.quo[qrs_pkg::COEF_WIDTH-2:0], 1'b1};
        end else begin
            n_q.rem = qrs_pkg::t_den'(w_t);
            n_q.quo = {i_d.quo[qrs_pkg::COEF_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

>>> sv/quadratic_root_solver.sv
// Top level of the quadratic root solver: front end, sqrt and divider cell chains, output skid.
// Depends on qrs_pkg, qrs_in_if, qrs_out_if, qrs_sqrt_cell and qrs_div_cell.
//
//   channel  | port           | direction | carries
//   ---------+----------------+-----------+------------------------------------------
//   coef     | i_coef         | in        | coef_a, coef_b, coef_c (signed Q16.16)
//   root     | o_root         | out       | root_count, root_minus, root_plus, saturated
//   config   | i_cfg_wr_*     | in        | zero_tolerance (16 bits, reset 1)
//
// One item enters per cycle while the skid is free; the pipe holds 3 front stages, 33 sqrt cells,
// 2 setup stages, 32 cells in each of two dividers, a result stage and the output register.
// The whole pipe advances together; a one-entry skid behind the output register lets it
// take one more item while a result waits. Reset is synchronous, clears the valid bits
// and sets the tolerance to 1.
module quadratic_root_solver (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  qrs_pkg::t_tol i_cfg_wr_data,
    qrs_in_if.sink        i_coef,
    qrs_out_if.source     o_root
);
    typedef struct packed {
        logic          vld;
        logic          sa, sb, sc;
        qrs_pkg::t_mag ma, mb, mc;
        logic          za, zb, zc;
    } t_s1;

    typedef struct packed {
        logic           vld;
        qrs_pkg::t_case code;
        logic           sa, sb, sc;
        qrs_pkg::t_mag  ma, mb, mc;
        logic           zc;
        qrs_pkg::t_prod b2, ac;
    } t_s2;

    typedef struct packed {
        logic           vld;
        qrs_pkg::t_case code;
        logic           sa, sb, sc;
        qrs_pkg::t_mag  ma, mb, mc;
        logic           zc;
        logic           dneg;
        logic           dbig;
    } t_sqsb;

    typedef struct packed {
        logic          vld;
        qrs_pkg::t_cnt cnt;
        qrs_pkg::t_sm  an;
        logic          asd;
        qrs_pkg::t_den amd;
        qrs_pkg::t_sm  bn;
        logic          bsd;
        qrs_pkg::t_den bmd;
    } t_sn;

    typedef struct packed {
        logic               vld;
        qrs_pkg::t_cnt      cnt;
        qrs_pkg::t_dv_flags fa;
        qrs_pkg::t_dv_flags fb;
    } t_dsb;

    typedef struct packed {
        qrs_pkg::t_cnt cnt;
        qrs_pkg::t_mag rm;
        qrs_pkg::t_mag rp;
        logic          sat;
    } t_res;

    qrs_pkg::t_tol     r_tol;
    logic              w_en;
    logic              w_in_fire;
    logic              w_out_fire;

    t_s1               n_s1, r_s1;
    t_s2               n_s2, r_s2;
    t_sqsb             n_sqsb0;
    t_sqsb             r_sqsb [0:qrs_pkg::SQRT_W];
    qrs_pkg::t_sq_cell n_sq0, r_sq0;
    qrs_pkg::t_sq_cell w_sq [0:qrs_pkg::SQRT_W];
    t_sn               n_sn, r_sn;
    qrs_pkg::t_dv_pre  w_pa, w_pb;
    qrs_pkg::t_dv_cell r_da0, r_db0;
    qrs_pkg::t_dv_cell w_da [0:qrs_pkg::COEF_WIDTH];
    qrs_pkg::t_dv_cell w_db [0:qrs_pkg::COEF_WIDTH];
    t_dsb              r_dsb [0:qrs_pkg::COEF_WIDTH];
    qrs_pkg::t_root    w_ra, w_rb;
    logic              r_fin_vld;
    t_res              n_fin, r_fin;
    logic              r_ov, r_sv;
    t_res              r_out, r_skid;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qrs_pkg::t_tol'(1);
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // Pipe moves whenever the skid is free
    assign w_en          = !r_sv;
    assign i_coef.ready  = w_en;
    assign w_in_fire     = i_coef.valid && w_en;
    assign w_out_fire    = r_ov && o_root.ready;

    // Stage 1: split into sign and magnitude, zero tests
    always_comb begin
        n_s1.vld = w_in_fire;
        n_s1.sa  = i_coef.coef_a[qrs_pkg::COEF_WIDTH-1];
        n_s1.sb  = i_coef.coef_b[qrs_pkg::COEF_WIDTH-1];
        n_s1.sc  = i_coef.coef_c[qrs_pkg::COEF_WIDTH-1];
        n_s1.ma  = n_s1.sa ? qrs_pkg::t_mag'(-i_coef.coef_a) : qrs_pkg::t_mag'(i_coef.coef_a);
        n_s1.mb  = n_s1.sb ? qrs_pkg::t_mag'(-i_coef.coef_b) : qrs_pkg::t_mag'(i_coef.coef_b);
        n_s1.mc  = n_s1.sc ? qrs_pkg::t_mag'(-i_coef.coef_c) : qrs_pkg::t_mag'(i_coef.coef_c);
        n_s1.za  = n_s1.ma < qrs_pkg::t_mag'(r_tol);
        n_s1.zb  = n_s1.mb < qrs_pkg::t_mag'(r_tol);
        n_s1.zc  = n_s1.mc < qrs_pkg::t_mag'(r_tol);
    end

    // Stage 2: case code and the two products
    always_comb begin
        n_s2.vld = r_s1.vld;
        n_s2.sa  = r_s1.sa;
        n_s2.sb  = r_s1.sb;
        n_s2.sc  = r_s1.sc;
        n_s2.ma  = r_s1.ma;
        n_s2.mb  = r_s1.mb;
        n_s2.mc  = r_s1.mc;
        n_s2.zc  = r_s1.zc;
        n_s2.b2  = qrs_pkg::t_prod'(r_s1.mb) * qrs_pkg::t_prod'(r_s1.mb);
        n_s2.ac  = qrs_pkg::t_prod'(r_s1.ma) * qrs_pkg::t_prod'(r_s1.mc);
        if (r_s1.za && r_s1.zb && r_s1.zc) begin
            n_s2.code = qrs_pkg::CS_INF;
        end else if (r_s1.za && r_s1.zb) begin
            n_s2.code = qrs_pkg::CS_NONE;
        end else if (r_s1.za) begin
            n_s2.code = qrs_pkg::CS_LIN;
        end else begin
            n_s2.code = qrs_pkg::CS_QUAD;
        end
    end

    // Stage 3: exact discriminant magnitude, sign and tolerance test
    always_comb begin
        qrs_pkg::t_disc b2x;
        qrs_pkg::t_disc ac4;
        qrs_pkg::t_disc disc;
        b2x = qrs_pkg::t_disc'(r_s2.b2);
        ac4 = {r_s2.ac, 2'b00};
        n_sqsb0.vld  = r_s2.vld;
        n_sqsb0.code = r_s2.code;
        n_sqsb0.sa   = r_s2.sa;
        n_sqsb0.sb   = r_s2.sb;
        n_sqsb0.sc   = r_s2.sc;
        n_sqsb0.ma   = r_s2.ma;
        n_sqsb0.mb   = r_s2.mb;
        n_sqsb0.mc   = r_s2.mc;
        n_sqsb0.zc   = r_s2.zc;
        if ((r_s2.sa != r_s2.sc) && (r_s2.mc != '0)) begin
            disc         = b2x + ac4;
            n_sqsb0.dneg = 1'b0;
        end else if (b2x >= ac4) begin
            disc         = b2x - ac4;
            n_sqsb0.dneg = 1'b0;
        end else begin
            disc         = ac4 - b2x;
            n_sqsb0.dneg = 1'b1;
        end
        n_sqsb0.dbig = qrs_pkg::t_dcmp'(disc) >=
                       (qrs_pkg::t_dcmp'(r_tol) << qrs_pkg::FRAC_BITS);
        n_sq0.rad  = disc;
        n_sq0.rem  = '0;
        n_sq0.root = '0;
    end

    // Front stage registers and the sqrt sideband line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            for (int k = 0; k <= qrs_pkg::SQRT_W; k++) begin
                r_sqsb[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_s1      <= n_s1;
            r_s2      <= n_s2;
            r_sq0     <= n_sq0;
            r_sqsb[0] <= n_sqsb0;
            for (int k = 1; k <= qrs_pkg::SQRT_W; k++) begin
                r_sqsb[k] <= r_sqsb[k-1];
            end
        end
    end

    // Square-root chain
    assign w_sq[0] = r_sq0;
    for (genvar g = 0; g < qrs_pkg::SQRT_W; g++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sq[g]),
            .o_q   (w_sq[g+1])
        );
    end

    // Numerators and denominators for the two dividers
    always_comb begin
        t_sqsb        sb;
        qrs_pkg::t_num sq;
        qrs_pkg::t_num mbx;
        sb  = r_sqsb[qrs_pkg::SQRT_W];
        sq  = qrs_pkg::t_num'(w_sq[qrs_pkg::SQRT_W].root);
        mbx = qrs_pkg::t_num'(sb.mb);
        n_sn.vld = sb.vld;
        n_sn.cnt = qrs_pkg::CNT_NONE;
        n_sn.an  = '0;
        n_sn.bn  = '0;
        n_sn.asd = sb.sa;
        n_sn.amd = {sb.ma, 1'b0};
        n_sn.bsd = sb.sa;
        n_sn.bmd = {sb.ma, 1'b0};
        case (sb.code)
            qrs_pkg::CS_INF: begin
                n_sn.cnt = qrs_pkg::CNT_INF;
            end
            qrs_pkg::CS_NONE: begin
                n_sn.cnt = qrs_pkg::CNT_NONE;
            end
            qrs_pkg::CS_LIN: begin
                n_sn.cnt = qrs_pkg::CNT_ONE;
                n_sn.asd = sb.sb;
                n_sn.amd = qrs_pkg::t_den'(sb.mb);
                if (!sb.zc) begin
                    n_sn.an.neg = !sb.sc;
                    n_sn.an.mag = qrs_pkg::t_num'(sb.mc);
                end
            end
            qrs_pkg::CS_QUAD: begin
                if (sb.dbig) begin
                    if (!sb.dneg) begin
                        n_sn.cnt = qrs_pkg::CNT_TWO;
                        n_sn.an  = qrs_pkg::sm_add(!sb.sb, mbx, 1'b1, sq);
                        n_sn.bn  = qrs_pkg::sm_add(!sb.sb, mbx, 1'b0, sq);
                    end
                end else begin
                    n_sn.cnt    = qrs_pkg::CNT_ONE;
                    n_sn.an.neg = !sb.sb;
                    n_sn.an.mag = mbx;
                end
            end
            default: begin
                n_sn.cnt = qrs_pkg::CNT_NONE;
            end
        endcase
    end

    assign w_pa = qrs_pkg::dv_pre(r_sn.an, r_sn.asd, r_sn.amd);
    assign w_pb = qrs_pkg::dv_pre(r_sn.bn, r_sn.bsd, r_sn.bmd);

    // Setup registers and the divider sideband line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn.vld <= 1'b0;
            for (int k = 0; k <= qrs_pkg::COEF_WIDTH; k++) begin
                r_dsb[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_sn         <= n_sn;
            r_da0        <= w_pa.c;
            r_db0        <= w_pb.c;
            r_dsb[0].vld <= r_sn.vld;
            r_dsb[0].cnt <= r_sn.cnt;
            r_dsb[0].fa  <= w_pa.f;
            r_dsb[0].fb  <= w_pb.f;
            for (int k = 1; k <= qrs_pkg::COEF_WIDTH; k++) begin
                r_dsb[k] <= r_dsb[k-1];
            end
        end
    end

    // Divider chains: minus root and plus root
    assign w_da[0] = r_da0;
    assign w_db[0] = r_db0;
    for (genvar g = 0; g < qrs_pkg::COEF_WIDTH; g++) begin : g_div
        qrs_div_cell u_cell_a (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_da[g]),
            .o_q   (w_da[g+1])
        );
        qrs_div_cell u_cell_b (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_db[g]),
            .o_q   (w_db[g+1])
        );
    end

    // Result stage: sign, clamp, flag
    assign w_ra = qrs_pkg::root_out(r_dsb[qrs_pkg::COEF_WIDTH].fa, w_da[qrs_pkg::COEF_WIDTH].quo);
    assign w_rb = qrs_pkg::root_out(r_dsb[qrs_pkg::COEF_WIDTH].fb, w_db[qrs_pkg::COEF_WIDTH].quo);

    always_comb begin
        n_fin.cnt = r_dsb[qrs_pkg::COEF_WIDTH].cnt;
        n_fin.rm  = w_ra.val;
        n_fin.rp  = w_rb.val;
        n_fin.sat = w_ra.sat | w_rb.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (w_en) begin
            r_fin_vld <= r_dsb[qrs_pkg::COEF_WIDTH].vld;
            r_fin     <= n_fin;
        end
    end

    // Output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_out_fire) begin
                r_out <= r_skid;
                r_sv  <= 1'b0;
            end
        end else if (r_fin_vld) begin
            if (!r_ov || w_out_fire) begin
                r_out <= r_fin;
                r_ov  <= 1'b1;
            end else begin
                r_skid <= r_fin;
                r_sv   <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_ov <= 1'b0;
        end
    end

    assign o_root.valid      = r_ov;
    assign o_root.root_count = r_out.cnt;
    assign o_root.root_minus = r_out.rm;
    assign o_root.root_plus  = r_out.rp;
    assign o_root.saturated  = r_out.sat;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds an item while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !o_root.ready) |=> r_sv)
        else $error("skid item dropped while the output stalls");

    a_plus_only_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_out.cnt != qrs_pkg::CNT_TWO)) |-> (r_out.rp == '0))
        else $error("plus root set without two roots");

    a_no_root_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && ((r_out.cnt == qrs_pkg::CNT_NONE) || (r_out.cnt == qrs_pkg::CNT_INF)))
        |-> ((r_out.rm == '0) && !r_out.sat))
        else $error("root value or clamp flag set with no finite root");
`endif

endmodule
